// ===== hw/rtl/gpc_pkg.sv =====
// ----------------------------------------------------------------------------
// gpc_pkg
// Shared widths, constants and types of the green pixel centroid unit.
// ----------------------------------------------------------------------------
`default_nettype none

package gpc_pkg;

  localparam int PIX_W       = 8;
  localparam int COORD_W     = 12;
  localparam int HITS_W      = 25;
  localparam int SUM_W       = 36;
  localparam int DATA_W      = 32;
  localparam int ADDR_W      = 3;

  localparam int MAX_COLUMNS_DEF = 4096;
  localparam int MAX_ROWS_DEF    = 4096;
  localparam int COORD_CAP       = 4095;

  localparam logic [PIX_W-1:0] MARGIN_RESET = 8'd50;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  localparam int DIV_STEPS = SUM_W;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);

  localparam logic KIND_MASK     = 1'b0;
  localparam logic KIND_CENTROID = 1'b1;

  localparam logic REG_GREEN_MARGIN = 1'b0;

  typedef struct packed {
    logic              green;
    logic              eof;
    logic [HITS_W-1:0] hits;
    logic [SUM_W-1:0]  col_sum;
    logic [SUM_W-1:0]  row_sum;
  } gpc_entry_t;

  typedef struct packed {
    logic load;
    logic step;
  } gpc_div_ctrl_t;

endpackage

`default_nettype wire

// ===== hw/rtl/gpc_front.sv =====
// ----------------------------------------------------------------------------
// gpc_front
// Classifies each pixel, tracks column and row, and accumulates the frame sums.
// ----------------------------------------------------------------------------
`default_nettype none

module gpc_front #(
  parameter int MAX_COLUMNS = gpc_pkg::MAX_COLUMNS_DEF,
  parameter int MAX_ROWS    = gpc_pkg::MAX_ROWS_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        fire,
  input  wire logic [gpc_pkg::PIX_W-1:0]   blue_value,
  input  wire logic [gpc_pkg::PIX_W-1:0]   green_value,
  input  wire logic [gpc_pkg::PIX_W-1:0]   red_value,
  input  wire logic                        end_of_line,
  input  wire logic                        end_of_frame,
  input  wire logic [gpc_pkg::PIX_W-1:0]   green_margin,
  output gpc_pkg::gpc_entry_t              entry
);
  import gpc_pkg::*;

  localparam int COL_LIM = (MAX_COLUMNS - 1 > COORD_CAP) ? COORD_CAP : MAX_COLUMNS - 1;
  localparam int ROW_LIM = (MAX_ROWS - 1 > COORD_CAP) ? COORD_CAP : MAX_ROWS - 1;
  localparam logic [COORD_W-1:0] COL_LIMIT = COORD_W'(COL_LIM);
  localparam logic [COORD_W-1:0] ROW_LIMIT = COORD_W'(ROW_LIM);

  logic [COORD_W-1:0] col_r, col_nxt;
  logic [COORD_W-1:0] row_r, row_nxt;
  logic [HITS_W-1:0]  hits_r, hits_nxt;
  logic [SUM_W-1:0]   csum_r, csum_nxt;
  logic [SUM_W-1:0]   rsum_r, rsum_nxt;

  logic [PIX_W:0]     red_lim;
  logic [PIX_W:0]     blue_lim;
  logic               is_green;
  logic [HITS_W:0]    hits_add;
  logic [SUM_W:0]     csum_add;
  logic [SUM_W:0]     rsum_add;
  logic [HITS_W-1:0]  hits_upd;
  logic [SUM_W-1:0]   csum_upd;
  logic [SUM_W-1:0]   rsum_upd;

  always_comb begin
    red_lim  = {1'b0, red_value} + {1'b0, green_margin};
    blue_lim = {1'b0, blue_value} + {1'b0, green_margin};
    is_green = ({1'b0, green_value} > red_lim) && ({1'b0, green_value} > blue_lim);

    hits_add = {1'b0, hits_r} + (HITS_W + 1)'(1);
    csum_add = {1'b0, csum_r} + (SUM_W + 1)'(col_r);
    rsum_add = {1'b0, rsum_r} + (SUM_W + 1)'(row_r);

    if (is_green) begin
      hits_upd = hits_add[HITS_W] ? '1 : hits_add[HITS_W-1:0];
      csum_upd = csum_add[SUM_W]  ? '1 : csum_add[SUM_W-1:0];
      rsum_upd = rsum_add[SUM_W]  ? '1 : rsum_add[SUM_W-1:0];
    end else begin
      hits_upd = hits_r;
      csum_upd = csum_r;
      rsum_upd = rsum_r;
    end

    entry.green   = is_green;
    entry.eof     = end_of_frame;
    entry.hits    = hits_upd;
    entry.col_sum = csum_upd;
    entry.row_sum = rsum_upd;
  end

  always_comb begin
    col_nxt  = col_r;
    row_nxt  = row_r;
    hits_nxt = hits_r;
    csum_nxt = csum_r;
    rsum_nxt = rsum_r;
    if (fire) begin
      if (end_of_frame) begin
        col_nxt  = '0;
        row_nxt  = '0;
        hits_nxt = '0;
        csum_nxt = '0;
        rsum_nxt = '0;
      end else begin
        hits_nxt = hits_upd;
        csum_nxt = csum_upd;
        rsum_nxt = rsum_upd;
        if (end_of_line) begin
          col_nxt = '0;
          if (row_r < ROW_LIMIT) begin
            row_nxt = row_r + COORD_W'(1);
          end
        end else if (col_r < COL_LIMIT) begin
          col_nxt = col_r + COORD_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r  <= '0;
      row_r  <= '0;
      hits_r <= '0;
      csum_r <= '0;
      rsum_r <= '0;
    end else begin
      col_r  <= col_nxt;
      row_r  <= row_nxt;
      hits_r <= hits_nxt;
      csum_r <= csum_nxt;
      rsum_r <= rsum_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/gpc_queue.sv =====
// ----------------------------------------------------------------------------
// gpc_queue
// Short first-in first-out queue of classified pixels between front and back.
// ----------------------------------------------------------------------------
`default_nettype none

module gpc_queue (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 wr_en,
  input  gpc_pkg::gpc_entry_t       wr_entry,
  output logic                      full,
  input  wire logic                 rd_en,
  output gpc_pkg::gpc_entry_t       rd_entry,
  output logic                      empty
);
  import gpc_pkg::*;

  gpc_entry_t          mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [QPTR_W:0]     count_r, count_nxt;
  logic                do_wr;
  logic                do_rd;

  always_comb begin
    full     = (count_r == (QPTR_W + 1)'(QUEUE_DEPTH));
    empty    = (count_r == '0);
    rd_entry = mem_r[rd_ptr_r];
    do_wr    = wr_en && !full;
    do_rd    = rd_en && !empty;

    wr_ptr_nxt = do_wr ? wr_ptr_r + QPTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = do_rd ? rd_ptr_r + QPTR_W'(1) : rd_ptr_r;
    count_nxt  = count_r;
    if (do_wr && !do_rd) begin
      count_nxt = count_r + (QPTR_W + 1)'(1);
    end else if (do_rd && !do_wr) begin
      count_nxt = count_r - (QPTR_W + 1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wr_ptr_r] <= wr_entry;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/gpc_divider.sv =====
// ----------------------------------------------------------------------------
// gpc_divider
// Restoring divider, one quotient bit per step, with the quotient clamped.
// ----------------------------------------------------------------------------
`default_nettype none

module gpc_divider (
  input  wire logic                          clk,
  input  gpc_pkg::gpc_div_ctrl_t             ctrl,
  input  wire logic [gpc_pkg::SUM_W-1:0]     dividend,
  input  wire logic [gpc_pkg::HITS_W-1:0]    divisor,
  output logic [gpc_pkg::COORD_W-1:0]        quotient
);
  import gpc_pkg::*;

  logic [SUM_W-1:0]  work_r, work_nxt;
  logic [HITS_W-1:0] rem_r, rem_nxt;
  logic [HITS_W-1:0] den_r, den_nxt;
  logic [HITS_W:0]   rem_sh;
  logic              q_bit;

  always_comb begin
    rem_sh   = {rem_r, work_r[SUM_W-1]};
    q_bit    = (rem_sh >= {1'b0, den_r});
    work_nxt = work_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    if (ctrl.load) begin
      work_nxt = dividend;
      rem_nxt  = '0;
      den_nxt  = divisor;
    end else if (ctrl.step) begin
      work_nxt = {work_r[SUM_W-2:0], q_bit};
      rem_nxt  = q_bit ? HITS_W'(rem_sh - {1'b0, den_r}) : rem_sh[HITS_W-1:0];
    end
    quotient = (|work_r[SUM_W-1:COORD_W]) ? '1 : work_r[COORD_W-1:0];
  end

  always_ff @(posedge clk) begin
    work_r <= work_nxt;
    rem_r  <= rem_nxt;
    den_r  <= den_nxt;
  end

endmodule

`default_nettype wire

// ===== hw/rtl/gpc_back.sv =====
// ----------------------------------------------------------------------------
// gpc_back
// Drains the queue, emits mask results and computes the frame centroid.
// ----------------------------------------------------------------------------
`default_nettype none

module gpc_back (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  gpc_pkg::gpc_entry_t                q_entry,
  input  wire logic                          q_empty,
  output logic                               q_pop,
  input  wire logic                          pop,
  output logic                               empty,
  output logic                               out_result_kind,
  output logic                               out_pixel_is_green,
  output logic [gpc_pkg::COORD_W-1:0]        out_centroid_x,
  output logic [gpc_pkg::COORD_W-1:0]        out_centroid_y,
  output logic                               out_found_any,
  output logic [gpc_pkg::HITS_W-1:0]         out_green_count,
  output logic                               out_last_result
);
  import gpc_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_DIV  = 3'b010,
    ST_CENT = 3'b100
  } state_t;

  state_t               state_r, state_nxt;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic [HITS_W-1:0]    hits_r, hits_nxt;
  logic                 valid_r, valid_nxt;

  logic                 kind_r, kind_nxt;
  logic                 green_r, green_nxt;
  logic [COORD_W-1:0]   cx_r, cx_nxt;
  logic [COORD_W-1:0]   cy_r, cy_nxt;
  logic                 found_r, found_nxt;
  logic [HITS_W-1:0]    count_r, count_nxt;
  logic                 last_r, last_nxt;

  gpc_div_ctrl_t        div_ctrl;
  logic [COORD_W-1:0]   quot_x;
  logic [COORD_W-1:0]   quot_y;
  logic                 out_free;
  logic                 found;

  gpc_divider u_div_x (
    .clk      (clk),
    .ctrl     (div_ctrl),
    .dividend (q_entry.col_sum),
    .divisor  (q_entry.hits),
    .quotient (quot_x)
  );

  gpc_divider u_div_y (
    .clk      (clk),
    .ctrl     (div_ctrl),
    .dividend (q_entry.row_sum),
    .divisor  (q_entry.hits),
    .quotient (quot_y)
  );

  always_comb begin
    out_free   = !valid_r || pop;
    found      = (hits_r != '0);
    state_nxt  = state_r;
    cnt_nxt    = cnt_r;
    hits_nxt   = hits_r;
    valid_nxt  = valid_r && !pop;
    kind_nxt   = kind_r;
    green_nxt  = green_r;
    cx_nxt     = cx_r;
    cy_nxt     = cy_r;
    found_nxt  = found_r;
    count_nxt  = count_r;
    last_nxt   = last_r;
    q_pop      = 1'b0;
    div_ctrl   = '0;

    unique case (state_r)
      ST_IDLE: begin
        if (!q_empty && out_free) begin
          q_pop     = 1'b1;
          valid_nxt = 1'b1;
          kind_nxt  = KIND_MASK;
          green_nxt = q_entry.green;
          cx_nxt    = '0;
          cy_nxt    = '0;
          found_nxt = 1'b0;
          count_nxt = '0;
          last_nxt  = !q_entry.eof;
          if (q_entry.eof) begin
            div_ctrl.load = 1'b1;
            hits_nxt      = q_entry.hits;
            cnt_nxt       = '0;
            state_nxt     = ST_DIV;
          end
        end
      end
      ST_DIV: begin
        div_ctrl.step = 1'b1;
        cnt_nxt       = cnt_r + DIV_CNT_W'(1);
        if (cnt_r == DIV_CNT_W'(DIV_STEPS - 1)) begin
          state_nxt = ST_CENT;
        end
      end
      ST_CENT: begin
        if (out_free) begin
          valid_nxt = 1'b1;
          kind_nxt  = KIND_CENTROID;
          green_nxt = 1'b0;
          cx_nxt    = found ? quot_x : '0;
          cy_nxt    = found ? quot_y : '0;
          found_nxt = found;
          count_nxt = hits_r;
          last_nxt  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      valid_r <= 1'b0;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      valid_r <= valid_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    hits_r  <= hits_nxt;
    kind_r  <= kind_nxt;
    green_r <= green_nxt;
    cx_r    <= cx_nxt;
    cy_r    <= cy_nxt;
    found_r <= found_nxt;
    count_r <= count_nxt;
    last_r  <= last_nxt;
  end

  assign empty              = !valid_r;
  assign out_result_kind    = kind_r;
  assign out_pixel_is_green = green_r;
  assign out_centroid_x     = cx_r;
  assign out_centroid_y     = cy_r;
  assign out_found_any      = found_r;
  assign out_green_count    = count_r;
  assign out_last_result    = last_r;

endmodule

`default_nettype wire

// ===== hw/rtl/green_pixel_centroid_unit.sv =====
// ----------------------------------------------------------------------------
// green_pixel_centroid_unit
// Per-frame centroid of markedly green pixels in a raster pixel stream.
//
// Pixels enter through push/full, one beat per pixel, with end-of-line and
// end-of-frame marks. Every pixel produces one mask beat on the result queue
// (empty/pop); the last pixel of a frame produces a second beat that carries
// the centroid, the green pixel count and found_any.
// A pixel is accepted every cycle while the receiver keeps popping and no
// centroid is being computed. A mask beat passes the pixel queue and then the
// output register. The centroid beat follows its mask beat once the two
// bit-serial 36-step dividers finish; meanwhile the four-entry pixel queue
// fills and then holds full high. When the receiver stalls, one result is held on
// the ports and the queue absorbs up to four pixels before full rises.
// Reset clears the counters, sums and queues and sets green_margin to 50.
// green_margin is written through the APB port at any address with paddr[2] low (0 to 3).
// ----------------------------------------------------------------------------
`default_nettype none

module green_pixel_centroid_unit #(
  parameter int MAX_COLUMNS = gpc_pkg::MAX_COLUMNS_DEF,
  parameter int MAX_ROWS    = gpc_pkg::MAX_ROWS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          push,
  output logic                               full,
  input  wire logic [gpc_pkg::PIX_W-1:0]     in_blue_value,
  input  wire logic [gpc_pkg::PIX_W-1:0]     in_green_value,
  input  wire logic [gpc_pkg::PIX_W-1:0]     in_red_value,
  input  wire logic                          in_end_of_line,
  input  wire logic                          in_end_of_frame,
  output logic                               empty,
  input  wire logic                          pop,
  output logic                               out_result_kind,
  output logic                               out_pixel_is_green,
  output logic [gpc_pkg::COORD_W-1:0]        out_centroid_x,
  output logic [gpc_pkg::COORD_W-1:0]        out_centroid_y,
  output logic                               out_found_any,
  output logic [gpc_pkg::HITS_W-1:0]         out_green_count,
  output logic                               out_last_result,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [gpc_pkg::ADDR_W-1:0]    paddr,
  input  wire logic [gpc_pkg::DATA_W-1:0]    pwdata,
  output logic [gpc_pkg::DATA_W-1:0]         prdata,
  output logic                               pready
);
  import gpc_pkg::*;

  logic [PIX_W-1:0] margin_r, margin_nxt;
  logic             reg_hit;
  logic             in_fire;
  gpc_entry_t       front_entry;
  gpc_entry_t       q_entry;
  logic             q_empty;
  logic             q_pop;

  always_comb begin
    reg_hit    = (paddr[ADDR_W-1] == REG_GREEN_MARGIN);
    margin_nxt = margin_r;
    if (psel && penable && pwrite && pready && reg_hit) begin
      margin_nxt = pwdata[PIX_W-1:0];
    end
    prdata = reg_hit ? DATA_W'(margin_r) : '0;
  end

  assign pready  = 1'b1;
  assign in_fire = push && !full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      margin_r <= MARGIN_RESET;
    end else begin
      margin_r <= margin_nxt;
    end
  end

  gpc_front #(
    .MAX_COLUMNS (MAX_COLUMNS),
    .MAX_ROWS    (MAX_ROWS)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .fire         (in_fire),
    .blue_value   (in_blue_value),
    .green_value  (in_green_value),
    .red_value    (in_red_value),
    .end_of_line  (in_end_of_line),
    .end_of_frame (in_end_of_frame),
    .green_margin (margin_r),
    .entry        (front_entry)
  );

  gpc_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (push),
    .wr_entry (front_entry),
    .full     (full),
    .rd_en    (q_pop),
    .rd_entry (q_entry),
    .empty    (q_empty)
  );

  gpc_back u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .q_entry            (q_entry),
    .q_empty            (q_empty),
    .q_pop              (q_pop),
    .pop                (pop),
    .empty              (empty),
    .out_result_kind    (out_result_kind),
    .out_pixel_is_green (out_pixel_is_green),
    .out_centroid_x     (out_centroid_x),
    .out_centroid_y     (out_centroid_y),
    .out_found_any      (out_found_any),
    .out_green_count    (out_green_count),
    .out_last_result    (out_last_result)
  );

endmodule

`default_nettype wire
